### hw/rtl/assert_macros.svh
// Assertion macros shared by the controller RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/carpid_pkg.sv
// Shared types and constants for the cascaded angle/rate PID controller.
// No dependencies.
package carpid_pkg;

  typedef enum logic [2:0] {
    REG_OUTER_KP = 3'd0,
    REG_OUTER_KI = 3'd1,
    REG_OUTER_KD = 3'd2,
    REG_INNER_KP = 3'd3,
    REG_INNER_KI = 3'd4,
    REG_INNER_KD = 3'd5,
    REG_LOOP_MODE = 3'd6
  } reg_index_t;

  localparam logic [1:0] MODE_WRAP  = 2'd1;
  localparam logic [1:0] MODE_TIGHT = 2'd2;

  // Operand select for the shared multiplier.
  typedef enum logic [1:0] {
    TERM_P = 2'd0,
    TERM_I = 2'd1,
    TERM_D = 2'd2
  } term_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic  load;      // capture inputs
    logic  prep;      // form loop error, integral, derivative
    logic  inner;     // 1: inner loop selected
    logic  mul;       // start a product into the product register
    term_t term;
    logic  acc;       // add product into accumulator
    logic  finish;    // clamp and store loop output
  } dp_cmd_t;

endpackage

### hw/rtl/carpid_ctrl.sv
// Sequencer for the cascaded PID: steps two loops through six products.
// Depends on carpid_pkg and assert_macros.svh.
`include "assert_macros.svh"
module carpid_ctrl
  import carpid_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_fire,
  input  logic    out_taken,
  output logic    in_ready,
  output logic    out_valid,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_MUL, S_ACC, S_FIN, S_OUT
  } state_t;

  state_t      state;
  logic        inner;
  logic [1:0]  term;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      inner     <= 1'b0;
      term      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_taken) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_fire) begin
          state <= S_PREP;
          inner <= 1'b0;
        end
        S_PREP: begin
          state <= S_MUL;
          term  <= 2'd0;
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          if (term == 2'd2) state <= S_FIN;
          else begin
            term  <= term + 2'd1;
            state <= S_MUL;
          end
        end
        S_FIN: begin
          if (inner) state <= S_OUT;
          else begin
            inner <= 1'b1;
            state <= S_PREP;
          end
        end
        S_OUT: if (!out_valid || out_taken) begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold off the next input until the waiting result has been taken.
  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd        = '0;
    cmd.load   = in_fire;
    cmd.prep   = (state == S_PREP);
    cmd.inner  = inner;
    cmd.mul    = (state == S_MUL);
    cmd.term   = term_t'(term);
    cmd.acc    = (state == S_ACC);
    cmd.finish = (state == S_FIN);
  end

  `ASSERT_IMPL(a_term_range, clk, rst, state == S_ACC, term <= 2'd2,
    "term index out of range")
  `ASSERT_NEXT(a_fin_follows_d, clk, rst, state == S_ACC && term == 2'd2,
    state == S_FIN, "loop did not finish after derivative term")
  `ASSERT_NEXT(a_out_sets_valid, clk, rst,
    state == S_OUT && (!out_valid || out_taken), out_valid,
    "result not presented")

endmodule

### hw/rtl/carpid_dp.sv
// Datapath for the cascaded PID: error forming, one shared multiplier,
// accumulator and clamps. Depends on carpid_pkg.
module carpid_dp
  import carpid_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] target_angle,
  input  logic signed [31:0] measured_angle,
  input  logic signed [31:0] measured_rate,
  output logic signed [31:0] rate_command,
  output logic signed [15:0] drive_out
);

  localparam longint MAX32 = 64'sd2147483647;
  localparam longint ONE   = 64'sd1 <<< FRAC_BITS;
  localparam longint LI_R  = 25000 * ONE;
  localparam longint LO_R  = 30000 * ONE;
  localparam longint LT6_R = 6000 * ONE;
  localparam longint LT10_R = 10000 * ONE;
  localparam longint LIM_I  = (LI_R > MAX32) ? MAX32 : LI_R;
  localparam longint LIM_O  = (LO_R > MAX32) ? MAX32 : LO_R;
  localparam longint LIM_T6 = (LT6_R > MAX32) ? MAX32 : LT6_R;
  localparam longint LIM_T10 = (LT10_R > MAX32) ? MAX32 : LT10_R;
  localparam longint THR  = (1799 * ONE) / 10;
  localparam longint FULL = 360 * ONE;

  logic [31:0] outer_kp, outer_ki, outer_kd, inner_kp, inner_ki, inner_kd;
  logic [1:0]  loop_mode;

  logic signed [31:0] tgt, ang, rate;
  logic signed [31:0] outer_integral, outer_prev_error;
  logic signed [31:0] inner_integral, inner_prev_error;
  logic signed [31:0] err, integ, diff;
  logic signed [31:0] cmd_val;
  logic [63:0]        prod;
  logic               prod_neg;
  logic signed [63:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_kp <= 32'd655360;
      outer_ki <= 32'd0;
      outer_kd <= 32'd0;
      inner_kp <= 32'd19660800;
      inner_ki <= 32'd4588;
      inner_kd <= 32'd327680;
      loop_mode <= MODE_WRAP;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_OUTER_KP:  outer_kp <= cfg_data;
        REG_OUTER_KI:  outer_ki <= cfg_data;
        REG_OUTER_KD:  outer_kd <= cfg_data;
        REG_INNER_KP:  inner_kp <= cfg_data;
        REG_INNER_KI:  inner_ki <= cfg_data;
        REG_INNER_KD:  inner_kd <= cfg_data;
        REG_LOOP_MODE: loop_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Error forming, integral and derivative for the selected loop.
  logic signed [33:0] raw_err, err_s, ig_sum, d_raw;
  logic signed [33:0] err_c, ig_c, d_c;
  logic               wrap_ok;
  always_comb begin
    if (cmd.inner) raw_err = 34'(cmd_val) - 34'(rate);
    else           raw_err = 34'(tgt) - 34'(ang);
    wrap_ok = !cmd.inner && loop_mode == MODE_WRAP &&
              34'(tgt) <= 34'(THR) && 34'(tgt) >= -34'(THR);
    err_s = raw_err;
    if (wrap_ok) begin
      if (raw_err > 34'(THR))       err_s = raw_err - 34'(FULL);
      else if (raw_err < -34'(THR)) err_s = raw_err + 34'(FULL);
    end
    err_c = err_s;
    if (err_s > 34'(MAX32)) err_c = 34'(MAX32);
    else if (err_s < -34'(MAX32)) err_c = -34'(MAX32);
    ig_sum = err_c + 34'(cmd.inner ? inner_integral : outer_integral);
    ig_c = ig_sum;
    if (ig_sum > 34'(LIM_I)) ig_c = 34'(LIM_I);
    else if (ig_sum < -34'(LIM_I)) ig_c = -34'(LIM_I);
    d_raw = err_c - 34'(cmd.inner ? inner_prev_error : outer_prev_error);
    d_c = d_raw;
    if (d_raw > 34'(MAX32)) d_c = 34'(MAX32);
    else if (d_raw < -34'(MAX32)) d_c = -34'(MAX32);
  end

  // Multiplier operands: magnitude times gain, sign kept apart.
  logic signed [31:0] x;
  logic [31:0]        gain, mag;
  always_comb begin
    unique case (cmd.term)
      TERM_P:  x = err;
      TERM_I:  x = integ;
      TERM_D:  x = diff;
      default: x = err;
    endcase
    unique case (cmd.term)
      TERM_P:  gain = cmd.inner ? inner_kp : outer_kp;
      TERM_I:  gain = cmd.inner ? inner_ki : outer_ki;
      TERM_D:  gain = cmd.inner ? inner_kd : outer_kd;
      default: gain = outer_kp;
    endcase
    mag = x[31] ? 32'(-x) : x;
  end

  // Floor of signed product over 2^F; |x| < 2^31 and gain < 2^32 keep the
  // magnitude and the sum of three terms inside 64 signed bits.
  logic [63:0]        rnd;
  logic signed [63:0] term_v, sum;
  always_comb begin
    rnd = prod_neg ? prod + ((64'd1 << FRAC_BITS) - 64'd1) : prod;
    rnd = rnd >> FRAC_BITS;
    term_v = prod_neg ? -$signed(rnd) : $signed(rnd);
    sum = acc + term_v;
  end

  // Output clamps.
  logic signed [63:0] v1, v2, tl;
  always_comb begin
    v1 = acc;
    if (acc > 64'(LIM_O)) v1 = 64'(LIM_O);
    else if (acc < -64'(LIM_O)) v1 = -64'(LIM_O);
    tl = cmd.inner ? 64'(LIM_T10) : 64'(LIM_T6);
    v2 = v1;
    if (loop_mode == MODE_TIGHT) begin
      if (v1 > tl) v2 = tl;
      else if (v1 < -tl) v2 = -tl;
    end
  end

  logic signed [31:0] v2_32, drv_q;
  assign v2_32 = v2[31:0];
  assign drv_q = (v2_32 + (v2_32[31] ? 32'((64'sd1 <<< FRAC_BITS) - 1) : 32'sd0))
                 >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_integral   <= '0;
      outer_prev_error <= '0;
      inner_integral   <= '0;
      inner_prev_error <= '0;
    end else if (cmd.prep) begin
      if (cmd.inner) begin
        inner_integral   <= ig_c[31:0];
        inner_prev_error <= err_c[31:0];
      end else begin
        outer_integral   <= ig_c[31:0];
        outer_prev_error <= err_c[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt  <= target_angle;
      ang  <= measured_angle;
      rate <= measured_rate;
    end
    if (cmd.prep) begin
      err   <= err_c[31:0];
      integ <= ig_c[31:0];
      diff  <= d_c[31:0];
      acc   <= '0;
    end
    if (cmd.mul) begin
      prod     <= 64'(mag) * 64'(gain);
      prod_neg <= x[31];
    end
    if (cmd.acc) acc <= sum;
    if (cmd.finish) begin
      if (cmd.inner) drive_out <= drv_q[15:0];
      else begin
        cmd_val      <= v2_32;
        rate_command <= v2_32;
      end
    end
  end

endmodule

### hw/rtl/cascaded_angle_rate_pid.sv
// Top level of the cascaded angle/rate PID controller.
// Depends on carpid_pkg, carpid_ctrl and carpid_dp.
//
//  Channel  Handshake              Payload
//  input    in_valid / in_ready    target_angle, measured_angle, measured_rate
//  output   out_valid / out_ready  rate_command, drive_out
//  config   cfg_we                 cfg_idx, cfg_data
//
// Each item runs two loops of one prep state, three multiply/accumulate
// pairs and one clamp state, then one output state before the result;
// the single shared 32x32 multiplier forms the products one at a time.
// Reset clears gains to their defaults and loop state to zero.
// A stalled result holds the block before the next input is taken.
module cascaded_angle_rate_pid
  import carpid_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] target_angle,
  input  logic signed [31:0] measured_angle,
  input  logic signed [31:0] measured_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] rate_command,
  output logic signed [15:0] drive_out,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [31:0]        cfg_data
);

  dp_cmd_t cmd;
  logic    in_fire, out_taken;

  assign in_fire   = in_valid && in_ready;
  assign out_taken = out_valid && out_ready;

  carpid_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_taken, .in_ready, .out_valid, .cmd
  );

  carpid_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .cfg_we, .cfg_idx, .cfg_data,
    .target_angle, .measured_angle, .measured_rate,
    .rate_command, .drive_out
  );

endmodule
